// ===== design/ip4dq_pkg.sv =====
package ip4dq_pkg;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [9:0] MAX_OCTET = 10'd255;
   localparam logic [1:0] MAX_DIGITS = 2'd3;
   localparam logic [1:0] LAST_OCTET = 2'd3;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_EMPTY = 3'd1,
      ERR_NODOT = 3'd2,
      ERR_RANGE = 3'd3,
      ERR_TRAIL = 3'd4
   } err_type;

endpackage

// ===== design/ipv4_dotted_quad_parser_core.sv =====
// rsp_valid is set as a terminator passes from input register to result register.
// Throughput: one character item per cycle; an input register feeds the
// octet update logic, and a result register holds the output item.
// A terminator waits in the input register only while a result is stalled.
// Reset (synchronous, active high) empties both registers and clears parse state.
module ipv4_dotted_quad_parser_core
   import ip4dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_addr_valid,
   output logic [31:0] rsp_address_word,
   output logic [2:0]  rsp_error_kind
);

   logic        in_vld_ff;
   logic [7:0]  char_ff;

   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  value_ff, value_in;
   logic [31:0] accum_ff, accum_in;
   err_type     err_ff, err_in;

   logic        rsp_vld_ff;
   logic        rsp_ok_ff;
   logic [31:0] rsp_addr_ff;
   err_type     rsp_err_ff;

   logic        is_digit;
   logic        is_term;
   logic        ok;
   logic        advance;

   assign is_digit = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
   assign is_term  = (char_ff == CHAR_NUL);
   assign advance  = in_vld_ff && (!is_term || !rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      value_in = value_ff;
      accum_in = accum_ff;
      err_in   = err_ff;
      ok       = 1'b0;
      if (err_ff == ERR_NONE) begin
         if (is_digit && (cnt_ff != MAX_DIGITS)) begin
            value_in = 10'(value_ff * 10'd10 + {2'b00, char_ff - CHAR_ZERO});
            cnt_in   = 2'(cnt_ff + 2'd1);
         end else if (cnt_ff == 2'd0) begin
            err_in = ERR_EMPTY;
         end else if (pos_ff != LAST_OCTET) begin
            if (char_ff != CHAR_DOT) begin
               err_in = ERR_NODOT;
            end else if (value_ff > MAX_OCTET) begin
               err_in = ERR_RANGE;
            end else begin
               accum_in = accum_ff | (32'(value_ff[7:0]) << {pos_ff, 3'b000});
               pos_in   = 2'(pos_ff + 2'd1);
               cnt_in   = 2'd0;
               value_in = 10'd0;
            end
         end else begin
            if (value_ff > MAX_OCTET) begin
               err_in = ERR_RANGE;
            end else if (is_term) begin
               ok = 1'b1;
            end else begin
               err_in = ERR_TRAIL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         char_ff <= req_char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         cnt_ff   <= 2'd0;
         value_ff <= 10'd0;
         accum_ff <= 32'd0;
         err_ff   <= ERR_NONE;
      end else if (advance) begin
         if (is_term) begin
            pos_ff   <= 2'd0;
            cnt_ff   <= 2'd0;
            value_ff <= 10'd0;
            accum_ff <= 32'd0;
            err_ff   <= ERR_NONE;
         end else begin
            pos_ff   <= pos_in;
            cnt_ff   <= cnt_in;
            value_ff <= value_in;
            accum_ff <= accum_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && is_term) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (advance && is_term) begin
         rsp_ok_ff   <= ok;
         rsp_addr_ff <= ok ? (accum_ff | {value_ff[7:0], 24'd0}) : 32'd0;
         rsp_err_ff  <= ok ? ERR_NONE : err_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_addr_valid   = rsp_ok_ff;
   assign rsp_address_word = rsp_addr_ff;
   assign rsp_error_kind   = rsp_err_ff;

endmodule

// ===== design/ip4dq_checker.sv =====
module ip4dq_checker
   import ip4dq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_char_code,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_addr_valid,
   input logic [31:0] rsp_address_word,
   input logic [2:0]  rsp_error_kind
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr_valid)
         && $stable(rsp_address_word) && $stable(rsp_error_kind))
      else $error("result item changed while stalled");

   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_addr_valid == (rsp_error_kind == ERR_NONE)))
      else $error("valid flag disagrees with error code");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_addr_valid |-> rsp_address_word == 32'd0)
      else $error("address not cleared on error");

   // a fresh result follows an accepted terminator item via the input register
   a_term_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && (req_char_code == CHAR_NUL), 2))
      else $error("result without terminator");

endmodule

bind ipv4_dotted_quad_parser_core ip4dq_checker u_ip4dq_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ip4dq_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 425;
   localparam int NUM_CASES = 17;

   typedef struct packed {
      logic        addr_valid;
      logic [31:0] address_word;
      err_type     error_kind;
   } quad_result;

   typedef struct {
      string      text;
      bit         fixed;
      quad_result res;
   } quad_case;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_addr_valid;
   logic [31:0] rsp_address_word;
   logic [2:0]  rsp_error_kind;

   ipv4_dotted_quad_parser_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_addr_valid   (rsp_addr_valid),
      .rsp_address_word (rsp_address_word),
      .rsp_error_kind   (rsp_error_kind)
   );

   // predictor state
   logic [1:0]  oct_pos;
   logic [1:0]  digit_cnt;
   logic [9:0]  oct_val;
   logic [31:0] addr_acc;
   err_type     err_seen;

   quad_result  expected_quads [$];
   logic [7:0]  text_buf [$];
   int          chars_sent = 0;
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          send_idle = 0;
   int          recv_stall = 0;
   int          send_idle_by_phase [4] = '{0, 76, 0, 37};
   int          recv_stall_by_phase [4] = '{0, 0, 76, 37};

   quad_case cases [NUM_CASES] = '{
      '{"",                1'b1, '{1'b0, 32'h0000_0000, ERR_EMPTY}},
      '{"0.0.0.0",         1'b1, '{1'b1, 32'h0000_0000, ERR_NONE}},
      '{"255.255.255.255", 1'b1, '{1'b1, 32'hFFFF_FFFF, ERR_NONE}},
      '{"1.2.3.4",         1'b1, '{1'b1, 32'h0403_0201, ERR_NONE}},
      '{"001.010.100.099", 1'b0, '0},
      '{"256.1.1.1",       1'b1, '{1'b0, 32'h0000_0000, ERR_RANGE}},
      '{"1.2.3.256",       1'b1, '{1'b0, 32'h0000_0000, ERR_RANGE}},
      '{"1..2.3",          1'b1, '{1'b0, 32'h0000_0000, ERR_EMPTY}},
      '{".1.2.3.4",        1'b1, '{1'b0, 32'h0000_0000, ERR_EMPTY}},
      '{"1.2.3",           1'b1, '{1'b0, 32'h0000_0000, ERR_NODOT}},
      '{"1234.1.1.1",      1'b1, '{1'b0, 32'h0000_0000, ERR_NODOT}},
      '{"1.2.3.1234",      1'b1, '{1'b0, 32'h0000_0000, ERR_TRAIL}},
      '{"1.2.3.4.",        1'b1, '{1'b0, 32'h0000_0000, ERR_TRAIL}},
      '{"1.2.3.",          1'b1, '{1'b0, 32'h0000_0000, ERR_EMPTY}},
      '{"9x9.1.1.1",       1'b1, '{1'b0, 32'h0000_0000, ERR_NODOT}},
      '{"\377\001",        1'b0, '0},
      '{"192.168.0.99",    1'b0, '0}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_parse();
      oct_pos = 2'd0;
      digit_cnt = 2'd0;
      oct_val = 10'd0;
      addr_acc = 32'd0;
      err_seen = ERR_NONE;
   endfunction

   // returns 1 when the character is the terminator and res holds the parse
   function automatic bit parse_char(input logic [7:0] c, output quad_result res);
      bit is_digit;
      bit ok;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      ok = 1'b0;
      res = '0;
      if (err_seen == ERR_NONE) begin
         if (is_digit && digit_cnt < MAX_DIGITS) begin
            oct_val = 10'(oct_val * 10 + 10'(c - CHAR_ZERO));
            digit_cnt = digit_cnt + 2'd1;
         end else if (digit_cnt == 2'd0) begin
            err_seen = ERR_EMPTY;
         end else if (oct_pos != LAST_OCTET) begin
            if (c != CHAR_DOT) begin
               err_seen = ERR_NODOT;
            end else if (oct_val > MAX_OCTET) begin
               err_seen = ERR_RANGE;
            end else begin
               addr_acc = addr_acc | (32'(oct_val[7:0]) << (8 * oct_pos));
               oct_pos = oct_pos + 2'd1;
               digit_cnt = 2'd0;
               oct_val = 10'd0;
            end
         end else if (oct_val > MAX_OCTET) begin
            err_seen = ERR_RANGE;
         end else if (c == CHAR_NUL) begin
            ok = 1'b1;
         end else begin
            err_seen = ERR_TRAIL;
         end
      end
      if (c != CHAR_NUL) return 1'b0;
      if (ok) res = '{1'b1, addr_acc | (32'(oct_val[7:0]) << 24), ERR_NONE};
      else res = '{1'b0, 32'd0, err_seen};
      clear_parse();
      return 1'b1;
   endfunction

   task automatic send_char(input logic [7:0] c, input bit fixed, input quad_result fixed_res);
      quad_result res;
      int gap;
      req_valid <= 1'b1;
      req_char_code <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
      if (parse_char(c, res)) expected_quads.push_back(fixed ? fixed_res : res);
      gap = 0;
      while ($urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_char_code <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input bit fixed, input quad_result fixed_res);
      foreach (text_buf[i]) send_char(text_buf[i], 1'b0, '0);
      send_char(CHAR_NUL, fixed, fixed_res);
   endtask

   function automatic logic [7:0] random_char();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 8'($urandom_range(1, 255));
      if (r < 80) return 8'(CHAR_ZERO + $urandom_range(9));
      return CHAR_DOT;
   endfunction

   task automatic add_octet();
      int r;
      int v;
      int n;
      int div;
      r = $urandom_range(99);
      if (r < 70) v = $urandom_range(255);
      else if (r < 80) v = ($urandom_range(1) == 1) ? 255 : 0;
      else if (r < 95) v = $urandom_range(999);
      else v = $urandom_range(9999);
      n = (v < 10) ? 1 : (v < 100) ? 2 : (v < 1000) ? 3 : 4;
      if (n < 3 && $urandom_range(3) == 0) n = $urandom_range(n + 1, 3);
      div = 1;
      repeat (n - 1) div = div * 10;
      repeat (n) begin
         text_buf.push_back(8'(CHAR_ZERO + (v / div) % 10));
         div = div / 10;
      end
   endtask

   // mostly well-formed quads, some damaged, some noise
   task automatic build_random_text();
      int r;
      int m;
      int idx;
      r = $urandom_range(99);
      text_buf.delete();
      if (r < 85) begin
         for (int k = 0; k < 4; k++) begin
            add_octet();
            if (k < 3) text_buf.push_back(CHAR_DOT);
         end
         if (r >= 60) begin
            idx = $urandom_range(text_buf.size() - 1);
            m = $urandom_range(99);
            if (m < 25) text_buf[idx] = random_char();
            else if (m < 50) text_buf.delete(idx);
            else if (m < 75) text_buf.insert(idx, random_char());
            else text_buf.push_back(random_char());
         end
      end else begin
         repeat ($urandom_range(8)) text_buf.push_back(random_char());
      end
   endtask

   always @(posedge clock) begin
      quad_result want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_quads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: valid=%0b addr=%h err=%0d",
                        rsp_addr_valid, rsp_address_word, rsp_error_kind);
         end else begin
            want = expected_quads.pop_front();
            if (rsp_addr_valid !== want.addr_valid ||
                rsp_address_word !== want.address_word ||
                rsp_error_kind !== want.error_kind) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp valid=%0b addr=%h err=%0d, got valid=%0b addr=%h err=%0d",
                           want.addr_valid, want.address_word, want.error_kind,
                           rsp_addr_valid, rsp_address_word, rsp_error_kind);
            end
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int start;
      clear_parse();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (cases[i]) begin
         text_buf.delete();
         for (int j = 0; j < cases[i].text.len(); j++) text_buf.push_back(cases[i].text[j]);
         send_text(cases[i].fixed, cases[i].res);
      end
      for (int p = 0; p < 4; p++) begin
         send_idle = send_idle_by_phase[p];
         recv_stall = recv_stall_by_phase[p];
         start = chars_sent;
         while (chars_sent - start < PHASE_ITEMS) begin
            build_random_text();
            send_text(1'b0, '0);
         end
      end
      req_valid <= 1'b0;
      while (expected_quads.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
